// File: design/bsfb_pkg.sv
`timescale 1ns / 1ps

package bsfb_pkg;

    localparam int unsigned FQ_DEPTH = 2;

    localparam logic [7:0] FLAG_BYTE = 8'h5c;
    localparam logic [7:0] ESC_BYTE  = 8'h5d;
    localparam logic [7:0] ESC_FLAG  = 8'h7c;
    localparam logic [7:0] ESC_ESC   = 8'h7d;
    localparam logic [7:0] ADDR_BYTE = 8'h01;
    localparam logic [7:0] CTRL_SEQ0 = 8'h00;
    localparam logic [7:0] CTRL_SEQ1 = 8'h02;

    // One classified payload word as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       hdr;
        logic       seq;
        logic       esc;
        logic       last;
    } desc_t;

endpackage

// File: design/bsfb_front.sv
`timescale 1ns / 1ps

module bsfb_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_payload_byte,
    input  logic                 s_last_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output bsfb_pkg::desc_t      q_wdata
);
    import bsfb_pkg::*;

    logic seq_bit_reg;
    logic seq_bit_next;
    logic inside_frame_reg;
    logic inside_frame_next;

    assign s_ready = ~q_full;
    assign q_push  = s_valid & ~q_full;

    always_comb begin
        q_wdata.data = s_payload_byte;
        q_wdata.hdr  = ~inside_frame_reg;
        q_wdata.seq  = seq_bit_reg;
        q_wdata.esc  = (s_payload_byte == FLAG_BYTE) || (s_payload_byte == ESC_BYTE);
        q_wdata.last = s_last_byte;
    end

    always_comb begin
        seq_bit_next      = cfg_we ? cfg_wdata : seq_bit_reg;
        inside_frame_next = q_push ? ~s_last_byte : inside_frame_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_bit_reg      <= 1'b0;
            inside_frame_reg <= 1'b0;
        end else begin
            seq_bit_reg      <= seq_bit_next;
            inside_frame_reg <= inside_frame_next;
        end
    end

endmodule

// File: design/bsfb_queue.sv
`timescale 1ns / 1ps

module bsfb_queue #(
    parameter int unsigned DEPTH = bsfb_pkg::FQ_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bsfb_pkg::desc_t wdata,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output bsfb_pkg::desc_t head
);
    import bsfb_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    desc_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/bsfb_back.sv
`timescale 1ns / 1ps

module bsfb_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  bsfb_pkg::desc_t head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_line_byte,
    output logic            m_run_end,
    output logic            m_frame_end
);
    import bsfb_pkg::*;

    typedef enum logic [3:0] {
        ST_START,
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_HDR3,
        ST_DATA0,
        ST_DATA1,
        ST_BCC,
        ST_FLAG
    } step_t;

    step_t      step_reg;
    step_t      step_next;
    step_t      cur_step;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] line_reg;
    logic [7:0] line_next;
    logic       run_end_reg;
    logic       run_end_next;
    logic       frame_end_reg;
    logic       frame_end_next;
    logic [7:0] check_reg;
    logic [7:0] check_next;
    logic [7:0] ctrl;
    logic       fire;
    logic       done;

    assign m_valid     = m_valid_reg;
    assign m_line_byte = line_reg;
    assign m_run_end   = run_end_reg;
    assign m_frame_end = frame_end_reg;

    // The output register takes a new word whenever it is empty or being drained.
    assign fire = head_valid & (~m_valid_reg | m_ready);
    assign pop  = fire & done;
    assign ctrl = head.seq ? CTRL_SEQ1 : CTRL_SEQ0;

    always_comb begin
        if (step_reg == ST_START) begin
            cur_step = head.hdr ? ST_HDR0 : ST_DATA0;
        end else begin
            cur_step = step_reg;
        end
    end

    always_comb begin
        line_next      = FLAG_BYTE;
        frame_end_next = 1'b0;
        step_next      = ST_START;
        done           = 1'b0;
        check_next     = check_reg;
        unique case (cur_step)
            ST_HDR0: begin
                line_next = FLAG_BYTE;
                step_next = ST_HDR1;
            end
            ST_HDR1: begin
                line_next = ADDR_BYTE;
                step_next = ST_HDR2;
            end
            ST_HDR2: begin
                line_next = ctrl;
                step_next = ST_HDR3;
            end
            ST_HDR3: begin
                line_next  = ADDR_BYTE ^ ctrl;
                step_next  = ST_DATA0;
                check_next = '0;
            end
            ST_DATA0: begin
                line_next  = head.esc ? ESC_BYTE : head.data;
                check_next = check_reg ^ line_next;
                if (head.esc) begin
                    step_next = ST_DATA1;
                end else if (head.last) begin
                    step_next = ST_BCC;
                end else begin
                    done = 1'b1;
                end
            end
            ST_DATA1: begin
                line_next  = (head.data == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
                check_next = check_reg ^ line_next;
                if (head.last) begin
                    step_next = ST_BCC;
                end else begin
                    done = 1'b1;
                end
            end
            ST_BCC: begin
                // The check byte goes out raw, without stuffing.
                line_next = check_reg;
                step_next = ST_FLAG;
            end
            ST_FLAG: begin
                line_next      = FLAG_BYTE;
                frame_end_next = 1'b1;
                check_next     = '0;
                done           = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
        run_end_next = done;
        m_valid_next = fire | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ST_START;
            m_valid_reg <= 1'b0;
            check_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (fire) begin
                step_reg      <= step_next;
                check_reg     <= check_next;
                line_reg      <= line_next;
                run_end_reg   <= run_end_next;
                frame_end_reg <= frame_end_next;
            end
        end
    end

endmodule

// File: design/byte_stuffing_frame_builder_top.sv
`timescale 1ns / 1ps
// The first output word of an input word passes the descriptor queue and the output register.
// Throughput: one output word per cycle while m_ready is high and the queue is not empty; an
// input word yields 1 to 8 output words (header 4, stuffed payload 1 or 2, check byte and
// closing flag 2). The two-entry queue lets input words be taken while output is stalled.
// Reset (aresetn low, synchronous) empties the queue and output register and clears seq_bit.
module byte_stuffing_frame_builder_top #(
    parameter int unsigned QDEPTH = bsfb_pkg::FQ_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_payload_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_line_byte,
    output logic       m_run_end,
    output logic       m_frame_end
);
    import bsfb_pkg::*;

    desc_t q_wdata;
    desc_t q_head;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_head_valid;

    bsfb_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_last_byte    (s_last_byte),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_wdata        (q_wdata)
    );

    bsfb_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .wdata      (q_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    bsfb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (q_head_valid),
        .head        (q_head),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_line_byte (m_line_byte),
        .m_run_end   (m_run_end),
        .m_frame_end (m_frame_end)
    );

endmodule

// File: design/bsfb_checker.sv
`timescale 1ns / 1ps

module bsfb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_line_byte,
    input logic       m_run_end,
    input logic       m_frame_end
);
    import bsfb_pkg::*;

    // A stalled output word holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_byte)
            && $stable(m_run_end) && $stable(m_frame_end))
        else $error("output word changed while stalled");

    // The closing flag is always a flag byte and always ends its input word's run.
    a_close_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_run_end && (m_line_byte == FLAG_BYTE))
        else $error("closing flag malformed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind byte_stuffing_frame_builder_top bsfb_checker u_bsfb_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_line_byte (m_line_byte),
    .m_run_end   (m_run_end),
    .m_frame_end (m_frame_end)
);
